// File: rtl/pac_pkg.sv
// Shared types, constants and helpers for the polygon closest-point block.
// Used by every module under rtl/; depends on nothing.
package pac_pkg;

    localparam int COORD_BITS   = 24;
    localparam int MAX_VERTICES = 256;
    localparam int MIN_POLY     = 3;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int DIV_W        = ACC_W;
    localparam int DIV_CNT_W    = $clog2(DIFF_W);

    // stream word layout
    localparam int IN_X_LSB   = IDX_W;
    localparam int IN_Y_LSB   = IN_X_LSB + COORD_BITS;
    localparam int IN_Z_LSB   = IN_Y_LSB + COORD_BITS;
    localparam int IN_KEEP    = IN_Z_LSB + COORD_BITS;
    localparam int IN_DATA_W  = ((IN_KEEP + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z       = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] STATUS_INSIDE = 2'd0;
    localparam logic [1:0] STATUS_EDGE   = 2'd1;
    localparam logic [1:0] STATUS_FEW    = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    // one multiply-accumulate request
    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } mac_ctrl_t;

    function automatic diff_t sub_ext(input coord_t a, input coord_t b);
        sub_ext = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    function automatic logic [DIFF_W-1:0] mag_of(input diff_t d);
        mag_of = d[DIFF_W-1] ? -d : d;
    endfunction

endpackage

// File: rtl/pac_vtx_mem.sv
// Vertex table: one write port, one read port with registered read data.
// Depends on pac_pkg.
module pac_vtx_mem
    import pac_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  coord_t           wx,
    input  coord_t           wy,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output coord_t           rx,
    output coord_t           ry
);

    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rdata_reg;

    // write a vertex
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wy, wx};
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rx = rdata_reg[COORD_BITS-1:0];
    assign ry = rdata_reg[2*COORD_BITS-1:COORD_BITS];

endmodule

// File: rtl/pac_mac.sv
// Shared multiply-accumulate unit: registered 25x25 product, then accumulate.
// Depends on pac_pkg.
module pac_mac
    import pac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mac_ctrl_t ctrl,
    input  diff_t     op_a,
    input  diff_t     op_b,
    output acc_t      acc
);

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctrl_t                ctrl_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    acc_t                     base;
    acc_t                     prod_ext;

    // multiply stage
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl;
        end
    end

    // accumulate stage
    always_comb begin
        base     = ctrl_reg.clr ? acc_t'(0) : acc_reg;
        prod_ext = {prod_reg[PROD_W-1], prod_reg};
        acc_next = acc_reg;
        if (ctrl_reg.en) begin
            acc_next = ctrl_reg.neg ? base - prod_ext : base + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: rtl/pac_div.sv
// Serial scaler: round(mag * dot / len2) for 0 < dot < len2, one bit of mag
// per step with up to two conditional subtracts. Depends on pac_pkg.
module pac_div
    import pac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIFF_W-1:0] mag,
    input  logic [ACC_W-2:0]  dot,
    input  logic [ACC_W-2:0]  len2,
    output logic              done,
    output logic [DIFF_W-1:0] quot
);

    typedef enum logic [4:0] {
        DV_IDLE = 5'b00001,
        DV_ADD  = 5'b00010,
        DV_SUB  = 5'b00100,
        DV_RND  = 5'b01000,
        DV_DONE = 5'b10000
    } dv_state_t;

    dv_state_t               state_reg, state_next;
    logic [DIFF_W-1:0]       mag_reg, mag_next;
    logic [DIFF_W-1:0]       q_reg, q_next;
    logic [DIV_W-1:0]        r_reg, r_next;
    logic [DIV_W-1:0]        dot_reg, dot_next;
    logic [DIV_W-1:0]        len_reg, len_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]        twice_r;

    assign twice_r = {r_reg[DIV_W-2:0], 1'b0};

    // step sequencer
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        dot_next   = dot_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    mag_next   = mag;
                    dot_next   = {1'b0, dot};
                    len_next   = {1'b0, len2};
                    r_next     = '0;
                    q_next     = '0;
                    cnt_next   = DIV_CNT_W'(DIFF_W - 1);
                    state_next = DV_ADD;
                end
            end
            DV_ADD: begin
                r_next     = twice_r + (mag_reg[DIFF_W-1] ? dot_reg : '0);
                q_next     = {q_reg[DIFF_W-2:0], 1'b0};
                mag_next   = {mag_reg[DIFF_W-2:0], 1'b0};
                state_next = DV_SUB;
            end
            DV_SUB: begin
                if (r_reg >= len_reg) begin
                    r_next = r_reg - len_reg;
                    q_next = q_reg + 1'b1;
                end else if (cnt_reg == '0) begin
                    state_next = DV_RND;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = DV_ADD;
                end
            end
            DV_RND: begin
                if (twice_r >= len_reg) begin
                    q_next = q_reg + 1'b1;
                end
                state_next = DV_DONE;
            end
            DV_DONE: begin
                state_next = DV_IDLE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        dot_reg <= dot_next;
        len_reg <= len_next;
        cnt_reg <= cnt_next;
    end

    assign done = (state_reg == DV_DONE);
    assign quot = q_reg;

endmodule

// File: rtl/polygon_area_closest_point.sv
// Closest point on a closed polygon with even-odd containment test.
// A load word writes one vertex. A query with fewer than three vertices returns
// too-few status; else it runs the containment walk over every edge, and if
// outside, a multiply-accumulate projection per edge, interior projections
// via the serial scaler; the single multiplier and the scaler set the pace.
// Reset (aresetn low, synchronous) clears control and registers; table undefined.
module polygon_area_closest_point
    import pac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: vertex_index, coord_x, coord_y, coord_z, keep_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: near_x, near_y, near_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: status
    output logic [1:0]            m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [25:0] {
        ST_IDLE     = 26'h0000001,
        ST_CI_PREV  = 26'h0000002,
        ST_CI_PREVL = 26'h0000004,
        ST_CI_LATCH = 26'h0000008,
        ST_CI_M1    = 26'h0000010,
        ST_CI_M2    = 26'h0000020,
        ST_CI_W     = 26'h0000040,
        ST_CI_EVAL  = 26'h0000080,
        ST_PJ_START = 26'h0000100,
        ST_PJ_FIRST = 26'h0000200,
        ST_PJ_LATCH = 26'h0000400,
        ST_PJ_M1    = 26'h0000800,
        ST_PJ_M2    = 26'h0001000,
        ST_PJ_M3    = 26'h0002000,
        ST_PJ_M4    = 26'h0004000,
        ST_PJ_W     = 26'h0008000,
        ST_PJ_CLS   = 26'h0010000,
        ST_PJ_DVXS  = 26'h0020000,
        ST_PJ_DVX   = 26'h0040000,
        ST_PJ_DVYS  = 26'h0080000,
        ST_PJ_DVY   = 26'h0100000,
        ST_PJ_D1    = 26'h0200000,
        ST_PJ_D2    = 26'h0400000,
        ST_PJ_DX    = 26'h0800000,
        ST_PJ_DW    = 26'h1000000,
        ST_DONE     = 26'h2000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  vcount_reg, vcount_next;
    coord_t            base_z_reg, base_z_next;
    coord_t            px_reg, px_next, py_reg, py_next;
    coord_t            cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    coord_t            prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    coord_t            qx_reg, qx_next, qy_reg, qy_next;
    coord_t            res_x_reg, res_x_next, res_y_reg, res_y_next;
    coord_t            res_z_reg, res_z_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              inside_reg, inside_next;
    logic              have_reg, have_next;
    acc_t              best_reg, best_next;
    acc_t              len2_reg, len2_next;
    acc_t              dot_reg, dot_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [CNT_W-1:0]  n_cnt, n_m1, idx_p1, idx_p2;
    logic              s_accept, is_last, out_load;
    coord_t            s_x, s_y, s_z;
    logic [IDX_W-1:0]  s_idx;
    logic              s_keep;
    diff_t             ex, ey;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    coord_t            mem_rx, mem_ry;
    mac_ctrl_t         mac_ctrl;
    diff_t             mac_a, mac_b;
    acc_t              acc;
    logic              div_start, div_done;
    logic [DIFF_W-1:0] div_mag, div_q;
    logic signed [DIFF_W:0] sq;
    logic              crossing, flip;

    // unpack the input word
    assign s_idx  = s_tdata[IDX_W-1:0];
    assign s_x    = s_tdata[IN_X_LSB +: COORD_BITS];
    assign s_y    = s_tdata[IN_Y_LSB +: COORD_BITS];
    assign s_z    = s_tdata[IN_Z_LSB +: COORD_BITS];
    assign s_keep = s_tdata[IN_KEEP];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // saturate the vertex count and derive walk indexes
    assign n_cnt   = (vcount_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_reg;
    assign n_m1    = n_cnt - 1'b1;
    assign idx_p1  = {1'b0, idx_reg} + 1'b1;
    assign idx_p2  = {1'b0, idx_reg} + CNT_W'(2);
    assign is_last = ({1'b0, idx_reg} == n_m1);

    assign ex = sub_ext(cur_x_reg, prev_x_reg);
    assign ey = sub_ext(cur_y_reg, prev_y_reg);

    // containment crossing test on edge (cur, prev)
    assign crossing = ((cur_y_reg > py_reg) != (prev_y_reg > py_reg));
    assign flip = crossing && ((sub_ext(prev_y_reg, cur_y_reg) > 0)
                  ? acc[ACC_W-1] : (!acc[ACC_W-1] && acc != '0));

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // multiplier operand select
    always_comb begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        unique case (state_reg)
            ST_CI_M1: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a    = sub_ext(px_reg, cur_x_reg);
                mac_b    = sub_ext(prev_y_reg, cur_y_reg);
            end
            ST_CI_M2: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b0, neg: 1'b1};
                mac_a    = sub_ext(prev_x_reg, cur_x_reg);
                mac_b    = sub_ext(py_reg, cur_y_reg);
            end
            ST_PJ_M1: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a    = ex;
                mac_b    = ex;
            end
            ST_PJ_M2: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
                mac_a    = ey;
                mac_b    = ey;
            end
            ST_PJ_M3: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a    = sub_ext(px_reg, prev_x_reg);
                mac_b    = ex;
            end
            ST_PJ_M4: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
                mac_a    = sub_ext(py_reg, prev_y_reg);
                mac_b    = ey;
            end
            ST_PJ_D1: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a    = sub_ext(px_reg, qx_reg);
                mac_b    = sub_ext(px_reg, qx_reg);
            end
            ST_PJ_D2: begin
                mac_ctrl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
                mac_a    = sub_ext(py_reg, qy_reg);
                mac_b    = sub_ext(py_reg, qy_reg);
            end
            default: begin
                mac_ctrl = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_PJ_DVXS) || (state_reg == ST_PJ_DVYS);
    assign div_mag   = (state_reg == ST_PJ_DVYS) ? mag_of(ey) : mag_of(ex);
    // apply the edge sign to the scaled offset
    assign sq = (state_reg == ST_PJ_DVY)
                ? (ey[DIFF_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}))
                : (ex[DIFF_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}));

    // sequencer
    always_comb begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        base_z_next  = base_z_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        res_z_next   = res_z_reg;
        res_st_next  = res_st_reg;
        idx_next     = idx_reg;
        inside_next  = inside_reg;
        have_next    = have_reg;
        best_next    = best_reg;
        len2_next    = len2_reg;
        dot_next     = dot_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg;

        // configuration writes
        if (cfg_valid) begin
            if (cfg_index == CFG_VERTEX_COUNT) begin
                vcount_next = cfg_data[CNT_W-1:0];
            end else if (cfg_index == CFG_BASE_Z) begin
                base_z_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == CMD_LOAD) begin
                        mem_we = ({1'b0, s_idx} < CNT_W'(MAX_VERTICES));
                    end else begin
                        px_next     = s_x;
                        py_next     = s_y;
                        res_x_next  = s_x;
                        res_y_next  = s_y;
                        res_z_next  = s_keep ? s_z : base_z_reg;
                        inside_next = 1'b0;
                        if (n_cnt < CNT_W'(MIN_POLY)) begin
                            res_st_next = STATUS_FEW;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_CI_PREV;
                        end
                    end
                end
            end
            ST_CI_PREV: begin
                mem_re     = 1'b1;
                mem_raddr  = n_m1[IDX_W-1:0];
                state_next = ST_CI_PREVL;
            end
            ST_CI_PREVL: begin
                prev_x_next = mem_rx;
                prev_y_next = mem_ry;
                mem_re      = 1'b1;
                mem_raddr   = '0;
                idx_next    = '0;
                state_next  = ST_CI_LATCH;
            end
            ST_CI_LATCH: begin
                cur_x_next = mem_rx;
                cur_y_next = mem_ry;
                state_next = ST_CI_M1;
            end
            ST_CI_M1: state_next = ST_CI_M2;
            ST_CI_M2: state_next = ST_CI_W;
            ST_CI_W:  state_next = ST_CI_EVAL;
            ST_CI_EVAL: begin
                inside_next = inside_reg ^ flip;
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                if (is_last) begin
                    if (inside_reg ^ flip) begin
                        res_st_next = STATUS_INSIDE;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_PJ_START;
                    end
                end else begin
                    idx_next   = idx_p1[IDX_W-1:0];
                    mem_re     = 1'b1;
                    mem_raddr  = idx_p1[IDX_W-1:0];
                    state_next = ST_CI_LATCH;
                end
            end
            ST_PJ_START: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_PJ_FIRST;
            end
            ST_PJ_FIRST: begin
                prev_x_next = mem_rx;
                prev_y_next = mem_ry;
                idx_next    = '0;
                have_next   = 1'b0;
                res_st_next = STATUS_EDGE;
                mem_re      = 1'b1;
                mem_raddr   = IDX_W'(1);
                state_next  = ST_PJ_LATCH;
            end
            ST_PJ_LATCH: begin
                cur_x_next = mem_rx;
                cur_y_next = mem_ry;
                state_next = ST_PJ_M1;
            end
            ST_PJ_M1: state_next = ST_PJ_M2;
            ST_PJ_M2: state_next = ST_PJ_M3;
            ST_PJ_M3: state_next = ST_PJ_M4;
            ST_PJ_M4: begin
                len2_next  = acc;
                state_next = ST_PJ_W;
            end
            ST_PJ_W: state_next = ST_PJ_CLS;
            // clamp: degenerate edge or behind start, past end, or interior
            ST_PJ_CLS: begin
                dot_next = acc;
                if (len2_reg == '0 || acc[ACC_W-1] || acc == '0) begin
                    qx_next    = prev_x_reg;
                    qy_next    = prev_y_reg;
                    state_next = ST_PJ_D1;
                end else if (acc >= len2_reg) begin
                    qx_next    = cur_x_reg;
                    qy_next    = cur_y_reg;
                    state_next = ST_PJ_D1;
                end else begin
                    state_next = ST_PJ_DVXS;
                end
            end
            ST_PJ_DVXS: state_next = ST_PJ_DVX;
            ST_PJ_DVX: begin
                if (div_done) begin
                    qx_next    = coord_t'($signed({prev_x_reg[COORD_BITS-1], prev_x_reg[COORD_BITS-1],
                                 prev_x_reg}) + sq);
                    state_next = ST_PJ_DVYS;
                end
            end
            ST_PJ_DVYS: state_next = ST_PJ_DVY;
            ST_PJ_DVY: begin
                if (div_done) begin
                    qy_next    = coord_t'($signed({prev_y_reg[COORD_BITS-1], prev_y_reg[COORD_BITS-1],
                                 prev_y_reg}) + sq);
                    state_next = ST_PJ_D1;
                end
            end
            ST_PJ_D1: state_next = ST_PJ_D2;
            ST_PJ_D2: state_next = ST_PJ_DX;
            ST_PJ_DX: state_next = ST_PJ_DW;
            ST_PJ_DW: begin
                // keep the first strict minimum
                if (!have_reg || acc < best_reg) begin
                    have_next  = 1'b1;
                    best_next  = acc;
                    res_x_next = qx_reg;
                    res_y_next = qy_reg;
                end
                if (is_last) begin
                    state_next = ST_DONE;
                end else begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    idx_next    = idx_p1[IDX_W-1:0];
                    mem_re      = 1'b1;
                    mem_raddr   = (idx_p2 == n_cnt) ? '0 : idx_p2[IDX_W-1:0];
                    state_next  = ST_PJ_LATCH;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // DW state samples acc once D2's product has passed the product and accumulator registers: acc holds d there

    // output register
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tdata_next  = OUT_DATA_W'({res_z_reg, res_y_reg, res_x_reg});
            m_tuser_next  = res_st_reg;
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= '0;
            base_z_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            inside_reg   <= 1'b0;
            have_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            base_z_reg   <= base_z_next;
            m_tvalid_reg <= m_tvalid_next;
            inside_reg   <= inside_next;
            have_reg     <= have_next;
        end
        px_reg      <= px_next;
        py_reg      <= py_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_z_reg   <= res_z_next;
        res_st_reg  <= res_st_next;
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        len2_reg    <= len2_next;
        dot_reg     <= dot_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    pac_vtx_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (s_idx),
        .wx    (s_x),
        .wy    (s_y),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rx    (mem_rx),
        .ry    (mem_ry)
    );

    pac_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (acc)
    );

    pac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (div_mag),
        .dot     (dot_reg[ACC_W-2:0]),
        .len2    (len2_reg[ACC_W-2:0]),
        .done    (div_done),
        .quot    (div_q)
    );

`ifndef SYNTHESIS
    // scaler finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_PJ_DVX || state_reg == ST_PJ_DVY))
        else $error("scaler done outside a wait state");

    // too-few status only when the table holds fewer than three vertices
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_st_reg == STATUS_FEW) |-> (n_cnt < CNT_W'(MIN_POLY)))
        else $error("too-few status with a full polygon");

    // multiplier idle while waiting for input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_ctrl.en)
        else $error("multiplier issued while idle");
`endif

endmodule

// File: verif/pac_checker.sv
// Scoreboard for polygon_area_closest_point: watches the config, input and result channels,
// predicts each query result from its own copy of the vertex table and compares.
// Depends on pac_pkg for widths and codes.
module pac_checker
    import pac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    seen_inside,
    output int                    seen_edge,
    output int                    seen_few
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        coord_t     z;
        logic [1:0] status;
    } near_t;

    longint     vtx_x [MAX_VERTICES];
    longint     vtx_y [MAX_VERTICES];
    logic [8:0] poly_count;
    coord_t     area_z;
    near_t      near_q[$];

    // e * dot / len2 rounded to nearest, ties away from zero (0 < dot < len2)
    function automatic longint scaled_step(longint e, longint dot, longint len2);
        logic [127:0] num, den, quo, rem;
        longint       me;
        me  = e < 0 ? -e : e;
        num = 128'(dot) * 128'(me);
        den = 128'(len2);
        quo = num / den;
        rem = num - quo * den;
        if ((rem << 1) >= den) quo = quo + 1;
        return e < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    // even-odd crossing test over the first n vertices
    function automatic bit point_inside(int n, longint px, longint py);
        bit     in_poly;
        int     j;
        longint dy, lhs, rhs;
        in_poly = 0;
        for (int i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            if ((vtx_y[i] > py) != (vtx_y[j] > py)) begin
                dy  = vtx_y[j] - vtx_y[i];
                lhs = (px - vtx_x[i]) * dy;
                rhs = (vtx_x[j] - vtx_x[i]) * (py - vtx_y[i]);
                if (dy > 0 ? lhs < rhs : lhs > rhs) in_poly = !in_poly;
            end
        end
        return in_poly;
    endfunction

    function automatic near_t nearest_point(coord_t cx, coord_t cy, coord_t cz, logic keep);
        near_t  r;
        int     n, k;
        longint px, py, ax, ay, ex, ey, qx, qy, len2, dot, d, best, rx, ry;
        bit     have;
        px = cx;
        py = cy;
        rx = px;
        ry = py;
        r.z = keep ? cz : area_z;
        n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        if (n < MIN_POLY) begin
            r.status = STATUS_FEW;
        end else if (point_inside(n, px, py)) begin
            r.status = STATUS_INSIDE;
        end else begin
            r.status = STATUS_EDGE;
            have = 0;
            best = 0;
            for (int i = 0; i < n; i++) begin
                k    = (i + 1 == n) ? 0 : i + 1;
                ax   = vtx_x[i];
                ay   = vtx_y[i];
                ex   = vtx_x[k] - ax;
                ey   = vtx_y[k] - ay;
                qx   = ax;
                qy   = ay;
                len2 = ex * ex + ey * ey;
                if (len2 > 0) begin
                    dot = (px - ax) * ex + (py - ay) * ey;
                    if (dot >= len2) begin
                        qx = ax + ex;
                        qy = ay + ey;
                    end else if (dot > 0) begin
                        qx = ax + scaled_step(ex, dot, len2);
                        qy = ay + scaled_step(ey, dot, len2);
                    end
                end
                d = (px - qx) * (px - qx) + (py - qy) * (py - qy);
                if (!have || d < best) begin
                    have = 1;
                    best = d;
                    rx   = qx;
                    ry   = qy;
                end
            end
        end
        r.x = rx[COORD_BITS-1:0];
        r.y = ry[COORD_BITS-1:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        near_t  want;
        coord_t gx, gy, gz;
        if (!aresetn) begin
            poly_count = '0;
            area_z     = '0;
            near_q.delete();
            errors      = 0;
            seen_inside = 0;
            seen_edge   = 0;
            seen_few    = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_VERTEX_COUNT) poly_count = cfg_data[8:0];
                else if (cfg_index == CFG_BASE_Z) area_z = cfg_data;
            end
            // input word: load a vertex or predict a query
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    vtx_x[s_tdata[IDX_W-1:0]] = coord_t'(s_tdata[IN_X_LSB +: COORD_BITS]);
                    vtx_y[s_tdata[IDX_W-1:0]] = coord_t'(s_tdata[IN_Y_LSB +: COORD_BITS]);
                end else begin
                    near_q.push_back(nearest_point(s_tdata[IN_X_LSB +: COORD_BITS],
                                                   s_tdata[IN_Y_LSB +: COORD_BITS],
                                                   s_tdata[IN_Z_LSB +: COORD_BITS],
                                                   s_tdata[IN_KEEP]));
                end
            end
            // result word: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                gx = m_tdata[0 +: COORD_BITS];
                gy = m_tdata[COORD_BITS +: COORD_BITS];
                gz = m_tdata[2*COORD_BITS +: COORD_BITS];
                if (near_q.size() == 0) begin
                    report("unexpected result, x", gx, 0);
                end else begin
                    want = near_q.pop_front();
                    if (gx != want.x) report("near_x", gx, want.x);
                    if (gy != want.y) report("near_y", gy, want.y);
                    if (gz != want.z) report("near_z", gz, want.z);
                    if (m_tuser != want.status) report("status", m_tuser, want.status);
                    case (want.status)
                        STATUS_INSIDE: seen_inside++;
                        STATUS_EDGE:   seen_edge++;
                        default:       seen_few++;
                    endcase
                end
            end
        end
        pending = near_q.size();
    end

endmodule

// File: verif/tb_polygon_area_closest_point.sv
// Top of the polygon_area_closest_point testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on pac_pkg, the block and pac_checker.
module tb_polygon_area_closest_point;
    import pac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam int IDLE_LIMIT = 400000;
    localparam int SETTLE     = 40;
    localparam int HOLD_LEN   = 3000;
    localparam longint CMAX   = 8388607;
    localparam longint CMIN   = -8388608;

    logic                  aclk;
    logic                  aresetn;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     errors, pending, seen_inside, seen_edge, seen_few;
    int     burst_left, idle_cycles, loads_sent, queries_sent;
    bit     start_hold;
    longint shape_x[MAX_VERTICES];
    longint shape_y[MAX_VERTICES];

    polygon_area_closest_point dut (.*);

    pac_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // send one word; the sender runs in bursts with random gaps
    task automatic push_word(logic cmd, int idx, longint x, longint y, longint z, logic keep);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, keep, coord_t'(z), coord_t'(y), coord_t'(x), idx[IDX_W-1:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_LOAD) loads_sent++;
        else queries_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // drop valid and wait until every expected result has come
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        drain();
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_vertex(int idx, longint x, longint y);
        if (idx < MAX_VERTICES) begin
            shape_x[idx] = x;
            shape_y[idx] = y;
        end
        push_word(CMD_LOAD, idx, x, y, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endtask

    function automatic longint pick(longint span);
        longint v;
        if (span >= CMAX) v = coord_t'($urandom());
        else v = longint'($urandom_range(0, 2 * span)) - span;
        return v;
    endfunction

    function automatic longint clip(longint v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    task automatic random_query(int n, longint span);
        longint x, y;
        int     k, sel;
        sel = $urandom_range(0, 9);
        k   = $urandom_range(0, n - 1);
        if (sel < 5) begin
            x = clip(pick(span + span / 2));
            y = clip(pick(span + span / 2));
        end else if (sel < 7) begin
            x = pick(CMAX);
            y = pick(CMAX);
        end else if (sel < 8) begin
            x = shape_x[k];
            y = shape_y[k];
        end else begin
            // midpoint of an edge, often exactly on it
            x = (shape_x[k] + shape_x[(k + 1) % n]) / 2;
            y = (shape_y[k] + shape_y[(k + 1) % n]) / 2;
        end
        push_word(CMD_QUERY, $urandom_range(0, 255), x, y, pick(CMAX), 1'($urandom_range(0, 1)));
    endtask

    // receiver: ready follows one of four randomly redrawn patterns, with one long hold-off
    initial begin
        int  mode, tick;
        bit  held;
        held = 0;
        tick = 0;
        mode = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (start_hold && !held) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            tick++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // watchdog on cycles with no accepted word anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb_polygon_area_closest_point: done, errors");
            $finish;
        end
    end

    initial begin
        int     n, polys;
        longint span;
        idle_cycles  = 0;
        burst_left   = 0;
        loads_sent   = 0;
        queries_sent = 0;
        start_hold   = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_LOAD;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no polygon yet: point comes straight back
        push_word(CMD_QUERY, 0, CMAX, CMIN, CMAX, 1'b1);
        push_word(CMD_QUERY, 255, CMIN, CMAX, CMIN, 1'b0);

        // square of side 160, plus a duplicated corner for a zero-length edge
        load_vertex(0, 0, 0);
        load_vertex(1, 160, 0);
        load_vertex(2, 160, 160);
        load_vertex(3, 0, 160);
        load_vertex(4, 0, 160);
        write_reg(CFG_VERTEX_COUNT, 2);
        push_word(CMD_QUERY, 7, 80, 80, 5, 1'b1);
        write_reg(CFG_BASE_Z, CMIN);
        write_reg(CFG_VERTEX_COUNT, 24'hABC004);
        push_word(CMD_QUERY, 0, 80, 80, 1, 1'b1);
        push_word(CMD_QUERY, 0, -50, 77, 2, 1'b0);
        push_word(CMD_QUERY, 0, 200, 213, 3, 1'b1);
        push_word(CMD_QUERY, 0, 160, 80, 4, 1'b0);
        push_word(CMD_QUERY, 0, 80, 0, 5, 1'b1);
        push_word(CMD_QUERY, 0, 0, 0, 6, 1'b0);
        push_word(CMD_QUERY, 0, CMAX, CMAX, CMAX, 1'b1);
        push_word(CMD_QUERY, 0, CMIN, CMIN, CMIN, 1'b0);
        push_word(CMD_QUERY, 0, 33, CMAX, 0, 1'b0);
        write_reg(CFG_BASE_Z, CMAX);
        write_reg(CFG_VERTEX_COUNT, 5);
        push_word(CMD_QUERY, 0, -7, 171, 0, 1'b0);
        push_word(CMD_QUERY, 0, 80, 81, 0, 1'b0);
        write_reg(CFG_SPARE, 24'h5A5A5A);
        push_word(CMD_QUERY, 0, 300, -300, 0, 1'b0);

        // random polygons with queries; receiver holds off during the first queries
        for (polys = 0; polys < 7; polys++) begin
            n = $urandom_range(3, 8);
            case ($urandom_range(0, 2))
                0:       span = 200;
                1:       span = 5000;
                default: span = CMAX;
            endcase
            write_reg(CFG_BASE_Z, pick(CMAX));
            for (int i = 0; i < n; i++) begin
                if (i > 0 && $urandom_range(0, 5) == 0) load_vertex(i, shape_x[i-1], shape_y[i-1]);
                else load_vertex(i, pick(span), pick(span));
            end
            // stray load beyond the polygon, harmless
            if ($urandom_range(0, 2) == 0) load_vertex($urandom_range(n, 255), pick(CMAX), pick(CMAX));
            write_reg(CFG_VERTEX_COUNT, n);
            if (polys == 0) start_hold = 1;
            repeat ($urandom_range(4, 7)) random_query(n, span);
            if (polys == 5) drain();
            // broken setup: too few vertices in use
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_VERTEX_COUNT, $urandom_range(0, 2));
                random_query(n, span);
            end
        end

        // smallest polygon once more
        write_reg(CFG_VERTEX_COUNT, 3);
        random_query(3, CMAX);

        drain();
        $display("covered %0d loads and %0d queries: %0d inside, %0d moved onto edge, %0d too few",
                 loads_sent, queries_sent, seen_inside, seen_edge, seen_few);
        if (errors == 0 && pending == 0)
            $display("tb_polygon_area_closest_point: done, clean");
        else
            $display("tb_polygon_area_closest_point: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/pac_pkg.sv
rtl/pac_vtx_mem.sv
rtl/pac_mac.sv
rtl/pac_div.sv
rtl/polygon_area_closest_point.sv
verif/pac_checker.sv
verif/tb_polygon_area_closest_point.sv
